// ===== hw/rtl/dale_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dale_pkg
// Command and status codes and controller states for the list engine, plus
// the value width and cell control bundle that its storage cells use.
// ----------------------------------------------------------------------------
package dale_pkg;

  localparam int unsigned ValW = 32;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_WRITE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DRAIN = 3'b010,
    S_OUT   = 3'b100
  } state_e;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
    logic capture;
    logic drain;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/dale_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dale_cell
// One list entry. Loads, shifts up or down with its neighbors, and carries a
// read value one place toward the head of the row per drain cycle.
// ----------------------------------------------------------------------------
module dale_cell import dale_pkg::*; #(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned POS   = 0
) (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic [CNT_W-1:0]   idx_i,
  input  logic [ValW-1:0]    wr_val_i,
  input  logic [ValW-1:0]    prev_val_i,
  input  logic [ValW-1:0]    next_val_i,
  input  logic [ValW-1:0]    next_bub_i,
  output logic [ValW-1:0]    val_o,
  output logic [ValW-1:0]    bub_o
);

  localparam logic [CNT_W-1:0] MyPos = CNT_W'(POS);

  logic [ValW-1:0] val_d, val_q;
  logic [ValW-1:0] bub_d, bub_q;
  logic            at_idx;
  logic            above;

  assign at_idx = (idx_i == MyPos);
  assign above  = (idx_i < MyPos);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.load && at_idx) begin
      val_d = wr_val_i;
    end else if (ctrl_i.shift_up && above) begin
      val_d = prev_val_i;
    end else if (ctrl_i.shift_down && (above || at_idx)) begin
      val_d = next_val_i;
    end
  end

  always_comb begin
    bub_d = bub_q;
    if (ctrl_i.capture) begin
      if (at_idx) begin
        bub_d = val_q;
      end
    end else if (ctrl_i.drain) begin
      bub_d = next_bub_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    bub_q <= bub_d;
  end

  assign val_o = val_q;
  assign bub_o = bub_q;

endmodule

// ===== hw/rtl/dynamic_array_list_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_array_list_engine_unit
// Ordered list of signed 32-bit values held in a row of register cells.
//
// One command beat in, one result beat out. The command channel is taken
// only while no command is in flight; in_stall_o is high from acceptance
// until the result beat has been taken.
// Append, insert, write and every failing command: result valid in the cycle
// after acceptance. Remove and read: the entry is picked up by its cell and
// walks one cell per cycle toward cell 0, where it is registered as the result.
// Insert and remove shift all later entries in the acceptance cycle.
// Reset empties the list and sets capacity to 2; cell contents are not
// cleared. While out_stall_i is high the result holds and no new command
// is taken.
// ----------------------------------------------------------------------------
module dynamic_array_list_engine_unit import dale_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       command_i,
  input  logic [CNT_W-1:0] index_i,
  input  logic [ValW-1:0]  value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ValW-1:0]  read_value_o,
  output logic [1:0]       status_o,
  output logic [CNT_W-1:0] list_length_o,
  output logic [CNT_W-1:0] list_capacity_o
);

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] TwoCnt = CNT_W'(2);

  function automatic logic [CNT_W-1:0] shrink_cap(input logic [CNT_W-1:0] n,
                                                  input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] cur;
    logic             done;
    cur  = c;
    done = 1'b0;
    if ({n, 2'b00} < {2'b00, c}) begin
      for (int j = 0; j < CNT_W; j++) begin
        if (!done) begin
          if (({1'b0, cur} > {n, 1'b0}) && (cur > TwoCnt)) begin
            cur = cur >> 1;
          end else begin
            done = 1'b1;
          end
        end
      end
    end
    return cur;
  endfunction

  state_e           state_d, state_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic [CNT_W-1:0] cap_d, cap_q;
  logic [CNT_W-1:0] drain_d, drain_q;
  logic [1:0]       st_d, st_q;
  logic [ValW-1:0]  rv_d, rv_q;
  logic             in_acc;
  logic             out_acc;
  logic             need_read;
  logic [CNT_W-1:0] cell_idx;
  logic [CNT_W-1:0] grown_cap;
  logic [CNT_W:0]   cap_x2;
  cell_ctrl_t       cmd_ctrl;
  cell_ctrl_t       cell_ctrl;
  logic [ValW-1:0]  val_w [MAX_ENTRIES];
  logic [ValW-1:0]  bub_w [MAX_ENTRIES];

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  assign cap_x2    = {cap_q, 1'b0};
  assign grown_cap = (count_q >= cap_q) ?
                     ((cap_x2 > {1'b0, MaxCnt}) ? MaxCnt : cap_x2[CNT_W-1:0]) : cap_q;

  always_comb begin
    st_d      = ST_OK;
    count_d   = count_q;
    cap_d     = cap_q;
    need_read = 1'b0;
    cmd_ctrl  = '0;
    cell_idx  = index_i;
    unique case (command_i)
      CMD_APPEND: begin
        cell_idx = count_q;
        if (count_q == MaxCnt) begin
          st_d = ST_FULL;
        end else begin
          cap_d         = grown_cap;
          count_d       = count_q + 1'b1;
          cmd_ctrl.load = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (index_i > count_q) begin
          st_d = ST_INDEX;
        end else if (count_q == MaxCnt) begin
          st_d = ST_FULL;
        end else begin
          cap_d             = grown_cap;
          count_d           = count_q + 1'b1;
          cmd_ctrl.load     = 1'b1;
          cmd_ctrl.shift_up = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (index_i >= count_q) begin
          st_d = ST_INDEX;
        end else begin
          count_d             = count_q - 1'b1;
          cap_d               = shrink_cap(count_q - 1'b1, cap_q);
          need_read           = 1'b1;
          cmd_ctrl.capture    = 1'b1;
          cmd_ctrl.shift_down = 1'b1;
        end
      end
      CMD_READ: begin
        if (index_i >= count_q) begin
          st_d = ST_INDEX;
        end else begin
          need_read        = 1'b1;
          cmd_ctrl.capture = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (index_i >= count_q) begin
          st_d = ST_INDEX;
        end else begin
          cmd_ctrl.load = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cell_ctrl       = in_acc ? cmd_ctrl : '0;
    cell_ctrl.drain = (state_q == S_DRAIN) && (drain_q != '0);
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    logic [ValW-1:0] prev_val;
    logic [ValW-1:0] next_val;
    logic [ValW-1:0] next_bub;
    if (k == 0) begin : g_head
      assign prev_val = val_w[k];
    end else begin : g_body
      assign prev_val = val_w[k-1];
    end
    if (k == MAX_ENTRIES - 1) begin : g_tail
      assign next_val = val_w[k];
      assign next_bub = '0;
    end else begin : g_link
      assign next_val = val_w[k+1];
      assign next_bub = bub_w[k+1];
    end
    dale_cell #(
      .CNT_W (CNT_W),
      .POS   (k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .idx_i      (cell_idx),
      .wr_val_i   (value_i),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .next_bub_i (next_bub),
      .val_o      (val_w[k]),
      .bub_o      (bub_w[k])
    );
  end

  always_comb begin
    state_d = state_q;
    drain_d = drain_q;
    rv_d    = rv_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rv_d    = '0;
          drain_d = index_i;
          state_d = need_read ? S_DRAIN : S_OUT;
        end
      end
      S_DRAIN: begin
        if (drain_q == '0) begin
          rv_d    = bub_w[0];
          state_d = S_OUT;
        end else begin
          drain_d = drain_q - 1'b1;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      cap_q   <= TwoCnt;
      drain_q <= '0;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
      if (in_acc) begin
        count_q <= count_d;
        cap_q   <= cap_d;
        st_q    <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rv_q <= rv_d;
  end

  assign read_value_o    = rv_q;
  assign status_o        = st_q;
  assign list_length_o   = count_q;
  assign list_capacity_o = cap_q;

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("command taken while a result is pending");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q >= TwoCnt) && (cap_q <= MaxCnt))
    else $error("capacity out of range");

  a_len_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("length exceeds capacity");

  a_drain_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) && (drain_q != '0) |=>
      (state_q == S_DRAIN) && (drain_q == $past(drain_q) - 1'b1))
    else $error("drain counter did not advance");

endmodule
